// ===== hw/rtl/dual_wheel_pd_position_drive_macros.svh =====
// assertion helpers shared by the drive blocks
// every use expects clk and rst_n in scope
`ifndef DUAL_WHEEL_PD_POSITION_DRIVE_MACROS_SVH
`define DUAL_WHEEL_PD_POSITION_DRIVE_MACROS_SVH
`ifndef SYNTHESIS
`define DWPD_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define DWPD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define DWPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DWPD_ASSERT_HOLDS(lbl, cond, msg)
`define DWPD_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define DWPD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/dwpd_pkg.sv =====
package dwpd_pkg;

  // item kinds
  localparam logic FUNC_CMD   = 1'b0;
  localparam logic FUNC_SENSE = 1'b1;

  // register map
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd2;

  localparam logic [15:0] GAIN_P_RST    = 16'd256;
  localparam logic [15:0] GAIN_D_RST    = 16'd0;
  localparam logic [15:0] TOLERANCE_RST = 16'd10;

  // position error: 24 bit goal minus 32 bit travelled
  localparam int DELTA_W = 33;
  // 17 bit signed gain times error
  localparam int PTERM_W = DELTA_W + 17;

  typedef struct packed {
    logic              func;
    logic signed [23:0] target_left;
    logic signed [23:0] target_right;
    logic signed [31:0] encoder_left;
    logic signed [31:0] encoder_right;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] spd_left;
    logic signed [15:0] spd_right;
    logic               done_res;
    logic               busy_res;
  } out_item_t;

  // classified item as held in the queue
  typedef struct packed {
    logic               func;
    logic signed [31:0] val_left;
    logic signed [31:0] val_right;
  } op_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [15:0]          data;
  } cfg_wr_t;

endpackage

// ===== hw/rtl/dwpd_front.sv =====
module dwpd_front import dwpd_pkg::*; (
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  output logic     push_valid,
  input  logic     push_ready,
  output op_t      push_op
);

  assign push_valid = in_valid;
  assign in_stall   = !push_ready;

  // keep only the fields the item kind uses
  always_comb begin
    push_op.func = in_item.func;
    if (in_item.func == FUNC_CMD) begin
      push_op.val_left  = 32'(in_item.target_left);
      push_op.val_right = 32'(in_item.target_right);
    end else begin
      push_op.val_left  = in_item.encoder_left;
      push_op.val_right = in_item.encoder_right;
    end
  end

endmodule

// ===== hw/rtl/dwpd_queue.sv =====
`include "dual_wheel_pd_position_drive_macros.svh"
module dwpd_queue import dwpd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  op_t  push_op,
  output logic pop_valid,
  input  logic pop_ready,
  output op_t  pop_op
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_op     = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  `DWPD_ASSERT_HOLDS(a_count_bound, count_r <= CNT_W'(DEPTH), "queue fill beyond depth")

endmodule

// ===== hw/rtl/dwpd_back.sv =====
`include "dual_wheel_pd_position_drive_macros.svh"
module dwpd_back import dwpd_pkg::*; #(
  parameter int GAIN_FRAC_BITS = 8,
  parameter int SPEED_WIDTH    = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_wr_t   cfg_wr,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  op_t       pop_op,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int SW      = SPEED_WIDTH;
  localparam int DTERM_W = SW + 17;
  localparam int SUM_W   = ((PTERM_W > DTERM_W) ? PTERM_W : DTERM_W) + 1;
  localparam logic signed [SUM_W-1:0] RND    = SUM_W'((1 << GAIN_FRAC_BITS) - 1);
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

  localparam logic ST_RUN    = 1'b0;
  localparam logic ST_SENSE2 = 1'b1;

  logic                      state_r, state_nxt;
  logic [15:0]               gain_p_r, gain_d_r, tol_r;
  logic signed [SW-1:0]      speed_r [2];
  logic signed [SW-1:0]      speed_nxt [2];
  logic signed [23:0]        goal_r [2];
  logic [31:0]               base_r [2];
  logic [31:0]               trav_r [2];
  logic [31:0]               pos_r [2];
  logic signed [DELTA_W-1:0] delta_r [2];
  logic signed [DELTA_W-1:0] delta_nxt [2];
  logic signed [PTERM_W-1:0] pterm_r [2];
  logic signed [DTERM_W-1:0] dterm_r [2];
  logic                      active_r, active_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_item_r, out_item_nxt;

  logic                      out_free, take, is_cmd, is_sense1, fin2, fin, done;
  logic                      cmd_arr, sen_arr;
  logic signed [DELTA_W-1:0] tgt [2];
  logic signed [DELTA_W-1:0] dnew [2];
  logic signed [DELTA_W-1:0] tol_s;
  logic signed [SUM_W-1:0]   sum_a [2];
  logic signed [SUM_W-1:0]   sum_b [2];
  logic signed [SUM_W-1:0]   quo [2];
  logic signed [SW-1:0]      pd [2];
  logic signed [SW-1:0]      new_sp [2];
  logic [31:0]               enc [2];

  function automatic logic is_small(input logic signed [SW-1:0] s);
    return (s == '0) || (s == SW'(1)) || (s == '1);
  endfunction

  assign out_free  = !out_valid_r || !out_stall;
  assign pop_ready = (state_r == ST_RUN) && ((pop_op.func == FUNC_SENSE) || out_free);
  assign take      = pop_valid && pop_ready;
  assign is_cmd    = take && (pop_op.func == FUNC_CMD);
  assign is_sense1 = take && (pop_op.func == FUNC_SENSE);
  assign fin2      = (state_r == ST_SENSE2) && out_free;
  assign tol_s     = $signed({{(DELTA_W - 16){1'b0}}, tol_r});
  assign tgt[0]    = DELTA_W'(pop_op.val_left);
  assign tgt[1]    = DELTA_W'(pop_op.val_right);
  assign enc[0]    = pop_op.val_left;
  assign enc[1]    = pop_op.val_right;

  // pd sum, rounded away from zero, then clamped
  always_comb begin
    for (int w = 0; w < 2; w++) begin
      sum_a[w] = SUM_W'(pterm_r[w]) - SUM_W'(dterm_r[w]);
      sum_b[w] = SUM_W'(pterm_r[w]) - SUM_W'(dterm_r[w]) + RND;
      quo[w]   = sum_a[w][SUM_W-1] ? (sum_a[w] >>> GAIN_FRAC_BITS)
                                   : (sum_b[w] >>> GAIN_FRAC_BITS);
      if (quo[w] > SAT_HI) begin
        pd[w] = SAT_HI[SW-1:0];
      end else if (quo[w] < SAT_LO) begin
        pd[w] = SAT_LO[SW-1:0];
      end else begin
        pd[w] = quo[w][SW-1:0];
      end
      new_sp[w] = active_r ? pd[w] : '0;
      dnew[w]   = DELTA_W'(goal_r[w]) - DELTA_W'($signed(trav_r[w]));
    end
  end

  assign cmd_arr = (tgt[0] < tol_s) && (tgt[0] > -tol_s) &&
                   (tgt[1] < tol_s) && (tgt[1] > -tol_s) &&
                   is_small(speed_r[0]) && is_small(speed_r[1]);
  assign sen_arr = active_r &&
                   (dnew[0] < tol_s) && (dnew[0] > -tol_s) &&
                   (dnew[1] < tol_s) && (dnew[1] > -tol_s) &&
                   is_small(new_sp[0]) && is_small(new_sp[1]);

  always_comb begin
    state_nxt  = state_r;
    active_nxt = active_r;
    fin        = 1'b0;
    done       = 1'b0;
    for (int w = 0; w < 2; w++) begin
      speed_nxt[w] = speed_r[w];
      delta_nxt[w] = delta_r[w];
    end
    unique case (state_r)
      ST_RUN: begin
        if (is_sense1) begin
          state_nxt = ST_SENSE2;
        end else if (is_cmd) begin
          for (int w = 0; w < 2; w++) begin
            delta_nxt[w] = tgt[w];
            speed_nxt[w] = cmd_arr ? '0 : speed_r[w];
          end
          active_nxt = !cmd_arr;
          done       = cmd_arr;
          fin        = 1'b1;
        end
      end
      ST_SENSE2: begin
        if (fin2) begin
          for (int w = 0; w < 2; w++) begin
            delta_nxt[w] = dnew[w];
            speed_nxt[w] = sen_arr ? '0 : new_sp[w];
          end
          active_nxt = active_r && !sen_arr;
          done       = sen_arr;
          fin        = 1'b1;
          state_nxt  = ST_RUN;
        end
      end
    endcase
    out_item_nxt.spd_left  = 16'(speed_nxt[0]);
    out_item_nxt.spd_right = 16'(speed_nxt[1]);
    out_item_nxt.done_res  = done;
    out_item_nxt.busy_res  = active_nxt;
    out_valid_nxt = fin ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      gain_p_r    <= GAIN_P_RST;
      gain_d_r    <= GAIN_D_RST;
      tol_r       <= TOLERANCE_RST;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int w = 0; w < 2; w++) begin
        speed_r[w] <= '0;
        goal_r[w]  <= '0;
        base_r[w]  <= '0;
        trav_r[w]  <= '0;
        pos_r[w]   <= '0;
        delta_r[w] <= '0;
      end
    end else begin
      if (cfg_wr.valid) begin
        unique case (cfg_wr.index)
          CFG_GAIN_P:    gain_p_r <= cfg_wr.data;
          CFG_GAIN_D:    gain_d_r <= cfg_wr.data;
          CFG_TOLERANCE: tol_r    <= cfg_wr.data;
          default: ;
        endcase
      end
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      for (int w = 0; w < 2; w++) begin
        speed_r[w] <= speed_nxt[w];
        delta_r[w] <= delta_nxt[w];
        if (is_cmd) begin
          goal_r[w] <= tgt[w][23:0];
          base_r[w] <= pos_r[w];
          trav_r[w] <= '0;
        end else if (is_sense1) begin
          pos_r[w]  <= enc[w];
          trav_r[w] <= enc[w] - base_r[w];
        end
      end
    end
  end

  // products for the pending sample, error and speed as they stood before it
  always_ff @(posedge clk) begin
    if (is_sense1) begin
      for (int w = 0; w < 2; w++) begin
        pterm_r[w] <= $signed({1'b0, gain_p_r}) * delta_r[w];
        dterm_r[w] <= $signed({1'b0, gain_d_r}) * speed_r[w];
      end
    end
    if (fin) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `DWPD_ASSERT_NEXT(a_sense_phase, is_sense1, state_r == ST_SENSE2, "second phase missed")
  `DWPD_ASSERT_IMPLIES(a_busy_track, out_valid_r, out_item_r.busy_res == active_r, "stale busy")
  `DWPD_ASSERT_IMPLIES(a_done_idle, done, !active_nxt, "done while busy")

endmodule

// ===== hw/rtl/dual_wheel_pd_position_drive.sv =====
// path: queue, back, output register; a sensor item also passes ST_SENSE2 and its
//   path is the speed loop: damping multiply, then sum, rounding and clamping;
//   throughput: one command item per cycle while output is free, none in ST_SENSE2
// reset: synchronous active-low rst_n clears queue, wheel state and gains to defaults,
//   no clearing pass
module dual_wheel_pd_position_drive import dwpd_pkg::*; #(
  parameter int GAIN_FRAC_BITS = 8,
  parameter int SPEED_WIDTH    = 16,
  parameter int QUEUE_DEPTH    = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input items
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  // result items
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  logic    push_valid, push_ready, pop_valid, pop_ready;
  op_t     push_op, pop_op;
  cfg_wr_t cfg_wr;

  // registers take a write in any cycle
  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  // front: sorts each item into command or sample and keeps only its fields
  dwpd_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op)
  );

  // short queue so the input side keeps taking items while the back works
  dwpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  // back: wheel state, pd update, arrival check and the output register
  dwpd_back #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .SPEED_WIDTH    (SPEED_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_op    (pop_op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== tb/dual_wheel_pd_position_drive_tb.sv =====
`timescale 1ns / 100ps

module dual_wheel_pd_position_drive_tb import dwpd_pkg::*; ();

  localparam int FRAC_BITS   = 8;
  localparam int PHASE_ITEMS = 225;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES  = 8;

  // receiver back-pressure styles, each held for a random stretch
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  // one row of the directed table; want is only used when typed is set
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } drive_row_t;

  // per accepted item: a hand-written expectation or none
  typedef struct {
    bit        typed;
    out_item_t want;
  } typed_mark_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_item = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_GAIN_P;
  logic [15:0]          cfg_data = '0;

  dual_wheel_pd_position_drive dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------
  // drive predictor: gains, wheel state and command state of its own
  // ---------------------------------------------------------------
  logic [15:0]        kp, kd, tol;
  logic signed [15:0] speed_l, speed_r;
  logic signed [23:0] goal_l, goal_r;
  logic [31:0]        base_l, base_r, trav_l, trav_r, pos_l, pos_r;
  logic               cmd_active;

  // pd law for one wheel: exact wide sum, round away from zero, clamp
  function automatic logic signed [15:0] pd_speed_calc(input logic signed [23:0] goal,
                                                       input logic [31:0] trav,
                                                       input logic signed [15:0] prev);
    longint err, sum, mag, q;
    err = longint'(goal) - longint'($signed(trav));
    sum = longint'(kp) * err - longint'(kd) * longint'(prev);
    mag = (sum < 0) ? -sum : sum;
    q = (mag + (longint'(1) << FRAC_BITS) - 1) >>> FRAC_BITS;
    if (sum < 0) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // a wheel counts as settled when close to its goal and nearly stopped
  function automatic bit wheel_settled(input logic signed [23:0] goal,
                                       input logic [31:0] trav,
                                       input logic signed [15:0] spd);
    longint err, sabs;
    err = longint'(goal) - longint'($signed(trav));
    if (err < 0) err = -err;
    sabs = longint'(spd);
    if (sabs < 0) sabs = -sabs;
    return (err < longint'(tol)) && (sabs <= 1);
  endfunction

  // works out the result of one accepted item and advances the state
  function automatic out_item_t predict_drive(input in_item_t it);
    out_item_t r;
    bit        fin;
    fin = 1'b0;
    if (it.func == FUNC_CMD) begin
      goal_l = it.target_left;
      goal_r = it.target_right;
      base_l = pos_l;
      base_r = pos_r;
      trav_l = '0;
      trav_r = '0;
      cmd_active = 1'b1;
    end else begin
      // speeds come from the travel seen before this sample
      if (cmd_active) begin
        speed_l = pd_speed_calc(goal_l, trav_l, speed_l);
        speed_r = pd_speed_calc(goal_r, trav_r, speed_r);
      end else begin
        speed_l = '0;
        speed_r = '0;
      end
      pos_l = it.encoder_left;
      pos_r = it.encoder_right;
      trav_l = pos_l - base_l;
      trav_r = pos_r - base_r;
    end
    if (cmd_active && wheel_settled(goal_l, trav_l, speed_l)
        && wheel_settled(goal_r, trav_r, speed_r)) begin
      speed_l = '0;
      speed_r = '0;
      cmd_active = 1'b0;
      fin = 1'b1;
    end
    r.spd_left  = speed_l;
    r.spd_right = speed_r;
    r.done_res  = fin;
    r.busy_res  = cmd_active;
    return r;
  endfunction

  // ---------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------
  out_item_t   expected_drive[$];
  typed_mark_t typed_marks[$];
  int          error_count = 0;
  int          items_accepted = 0;
  int          results_checked = 0;
  int          done_seen = 0;
  int          clamp_seen = 0;
  out_item_t   pred_res, want_res;
  typed_mark_t mark;

  task automatic flag_error(input string msg);
    error_count++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  // everything is sampled at the edge, so values are the pre-edge ones
  always @(posedge clk) begin
    if (!rst_n) begin
      kp = GAIN_P_RST;
      kd = GAIN_D_RST;
      tol = TOLERANCE_RST;
      speed_l = '0;
      speed_r = '0;
      goal_l = '0;
      goal_r = '0;
      base_l = '0;
      base_r = '0;
      trav_l = '0;
      trav_r = '0;
      pos_l = '0;
      pos_r = '0;
      cmd_active = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GAIN_P:    kp = cfg_data;
          CFG_GAIN_D:    kd = cfg_data;
          CFG_TOLERANCE: tol = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        pred_res = predict_drive(in_item);
        mark = typed_marks.pop_front();
        expected_drive = {expected_drive, (mark.typed ? mark.want : pred_res)};
        items_accepted++;
      end
      if (out_valid && !out_stall) begin
        if (expected_drive.size() == 0) begin
          flag_error("result item with nothing expected");
        end else begin
          want_res = expected_drive.pop_front();
          results_checked++;
          if (want_res.done_res) done_seen++;
          if (want_res.spd_left == 16'sh7fff || want_res.spd_left == 16'sh8000)
            clamp_seen++;
          if (out_item.spd_left !== want_res.spd_left)
            flag_error($sformatf("result %0d spd_left %0d, want %0d", results_checked,
                                 out_item.spd_left, want_res.spd_left));
          if (out_item.spd_right !== want_res.spd_right)
            flag_error($sformatf("result %0d spd_right %0d, want %0d", results_checked,
                                 out_item.spd_right, want_res.spd_right));
          if (out_item.done_res !== want_res.done_res)
            flag_error($sformatf("result %0d done_res %b, want %b", results_checked,
                                 out_item.done_res, want_res.done_res));
          if (out_item.busy_res !== want_res.busy_res)
            flag_error($sformatf("result %0d busy_res %b, want %b", results_checked,
                                 out_item.busy_res, want_res.busy_res));
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // receiver: stall style changes every so often, including none
  // ---------------------------------------------------------------
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_hold = 0;
  int          cycle_count = 0;

  always @(posedge clk) begin
    if (stall_hold == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_hold <= $urandom_range(20, 120);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 99) < 30);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 99) < 75);
      STALL_PERIODIC: out_stall <= (cycle_count % 3 == 0);
      default:        out_stall <= 1'b0;
    endcase
  end

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("dual_wheel_pd_position_drive_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // sender: items go out in bursts with idle gaps between them
  // ---------------------------------------------------------------
  int          burst_left = 0;
  int          items_sent = 0;
  logic [31:0] plant_left = '0;
  logic [31:0] plant_right = '0;

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    typed_mark_t m;
    m.typed = typed;
    m.want = want;
    typed_marks = {typed_marks, m};
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // now and then a long burst with no gaps at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(0, 12);
    end
  endtask

  // unused fields of each kind carry random bits
  task automatic send_cmd(input logic signed [23:0] tl, input logic signed [23:0] tr);
    in_item_t it;
    it.func = FUNC_CMD;
    it.target_left = tl;
    it.target_right = tr;
    it.encoder_left = $urandom;
    it.encoder_right = $urandom;
    send_item(it, 1'b0, '0);
  endtask

  task automatic send_sample(input logic [31:0] el, input logic [31:0] er);
    in_item_t it;
    it.func = FUNC_SENSE;
    it.target_left = 24'($urandom);
    it.target_right = 24'($urandom);
    it.encoder_left = el;
    it.encoder_right = er;
    plant_left = el;
    plant_right = er;
    send_item(it, 1'b0, '0);
  endtask

  // crude wheel motion: creep towards the goal, sometimes landing a little off
  function automatic logic [31:0] approach(input logic [31:0] cur, input logic [31:0] goal);
    int rem, s;
    rem = $signed(goal - cur);
    s = int'($urandom_range(1, 400));
    if (rem > s) return cur + s;
    if (rem < -s) return cur - s;
    if ($urandom_range(0, 9) == 0) return goal + 32'($urandom_range(0, 4)) - 32'd2;
    return goal;
  endfunction

  // mostly modest targets, some just inside tolerance, a few full range
  function automatic logic signed [23:0] pick_target();
    int r, v;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      v = int'($urandom_range(0, 6000)) - 3000;
      return 24'(v);
    end
    if (r < 92) begin
      v = int'($urandom_range(0, 40)) - 20;
      return 24'(v);
    end
    return 24'($urandom);
  endfunction

  // all three registers in one unbroken write sequence
  task automatic program_gains(input logic [15:0] p, input logic [15:0] d,
                               input logic [15:0] t);
    logic [CFG_IDX_W-1:0] idx[3];
    logic [15:0]          val[3];
    idx[0] = CFG_GAIN_P;
    idx[1] = CFG_GAIN_D;
    idx[2] = CFG_TOLERANCE;
    val[0] = p;
    val[1] = d;
    val[2] = t;
    cfg_valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // wait for every outstanding result, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_drive.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  drive_row_t directed_rows[$];

  function automatic void add_row(input logic f, input logic signed [23:0] tl,
                                  input logic signed [23:0] tr, input logic [31:0] el,
                                  input logic [31:0] er, input bit typed,
                                  input logic [15:0] sl, input logic [15:0] sr,
                                  input logic dn, input logic bz);
    drive_row_t row;
    row.item.func = f;
    row.item.target_left = tl;
    row.item.target_right = tr;
    row.item.encoder_left = el;
    row.item.encoder_right = er;
    row.typed = typed;
    row.want.spd_left = sl;
    row.want.spd_right = sr;
    row.want.done_res = dn;
    row.want.busy_res = bz;
    directed_rows = {directed_rows, row};
  endfunction

  logic [15:0]        ph_kp[NUM_PHASES];
  logic [15:0]        ph_kd[NUM_PHASES];
  logic [15:0]        ph_tol[NUM_PHASES];
  logic signed [23:0] tl, tr;
  logic [31:0]        gl, gr;
  int                 roll, steps, phase_end;

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, at reset gains (kp 1.0, kd 0, tolerance 10)
    // sample while idle: zero speeds, nothing running
    add_row(FUNC_SENSE, 24'sh5a5a5a, 24'sha5a5a5, 32'h0, 32'h0, 1, 16'h0, 16'h0, 0, 0);
    add_row(FUNC_SENSE, 24'sh0, 24'sh0, 32'h7fffffff, 32'h80000000,
            1, 16'h0, 16'h0, 0, 0);
    // zero target completes at once
    add_row(FUNC_CMD, 24'sh0, 24'sh0, 32'h5a5a5a5a, 32'ha5a5a5a5, 1, 16'h0, 16'h0, 1, 0);
    // extreme targets: busy with last speeds, then both speeds clamp
    add_row(FUNC_CMD, 24'sh7fffff, 24'sh800000, 32'hffffffff, 32'h0,
            1, 16'h0, 16'h0, 0, 1);
    add_row(FUNC_SENSE, 24'shffffff, 24'sh0, 32'h7fffffff, 32'h80000000,
            1, 16'h7fff, 16'h8000, 0, 1);
    // encoder wrap across the sign boundary
    add_row(FUNC_SENSE, 24'sh0, 24'shffffff, 32'h80000000, 32'h7fffffff,
            0, 16'h0, 16'h0, 0, 0);
    // command while busy keeps the speeds as damping history
    add_row(FUNC_CMD, 24'sd5, -24'sd5, 32'h0, 32'h0, 1, 16'h7fff, 16'h8000, 0, 1);
    add_row(FUNC_SENSE, 24'sh0, 24'sh0, 32'h80000000, 32'h7fffffff,
            0, 16'h0, 16'h0, 0, 0);
    add_row(FUNC_SENSE, 24'sh0, 24'sh0, 32'h80000005, 32'h7ffffffa,
            0, 16'h0, 16'h0, 0, 0);
    add_row(FUNC_SENSE, 24'sh0, 24'sh0, 32'h80000005, 32'h7ffffffa,
            0, 16'h0, 16'h0, 0, 0);
    // just inside tolerance completes at once, just outside does not
    add_row(FUNC_CMD, 24'sd9, -24'sd9, 32'h0, 32'h0, 1, 16'h0, 16'h0, 1, 0);
    add_row(FUNC_CMD, 24'sd10, -24'sd10, 32'h0, 32'h0, 1, 16'h0, 16'h0, 0, 1);
    add_row(FUNC_SENSE, 24'sh0, 24'sh0, 32'h80000005, 32'h7ffffffa,
            0, 16'h0, 16'h0, 0, 0);
    add_row(FUNC_CMD, -24'sd100, 24'sd100, 32'h0, 32'h0, 0, 16'h0, 16'h0, 0, 0);
    add_row(FUNC_SENSE, 24'sh0, 24'sh0, 32'h80000005 - 32'd50, 32'h7ffffffa + 32'd50,
            0, 16'h0, 16'h0, 0, 0);
    add_row(FUNC_SENSE, 24'sh0, 24'sh0, 32'h80000005 - 32'd50, 32'h7ffffffa + 32'd50,
            0, 16'h0, 16'h0, 0, 0);
    add_row(FUNC_CMD, 24'sh0, 24'sh0, 32'h0, 32'h0, 0, 16'h0, 16'h0, 0, 0);
    add_row(FUNC_SENSE, 24'sh0, 24'sh0, 32'h80000005 - 32'd50, 32'h7ffffffa + 32'd50,
            0, 16'h0, 16'h0, 0, 0);
    add_row(FUNC_SENSE, 24'sh0, 24'sh0, 32'h0000ffff, 32'hffff0000,
            1, 16'h0, 16'h0, 0, 0);
    add_row(FUNC_CMD, 24'sh800000, 24'sh7fffff, 32'hffffffff, 32'hffffffff,
            1, 16'h0, 16'h0, 0, 1);
    add_row(FUNC_SENSE, 24'sh0, 24'sh0, 32'h0000ffff, 32'hffff0000,
            1, 16'h8000, 16'h7fff, 0, 1);
    add_row(FUNC_CMD, 24'sd1, -24'sd1, 32'h0, 32'h0, 0, 16'h0, 16'h0, 0, 0);
    add_row(FUNC_SENSE, 24'sh0, 24'sh0, 32'h0000ffff, 32'hffff0000,
            0, 16'h0, 16'h0, 0, 0);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      if (directed_rows[i].item.func == FUNC_SENSE) begin
        plant_left = directed_rows[i].item.encoder_left;
        plant_right = directed_rows[i].item.encoder_right;
      end
    end
    drain();

    // gain settings: defaults, both extremes, rounding cases, then random
    ph_kp[0] = GAIN_P_RST;  ph_kd[0] = GAIN_D_RST; ph_tol[0] = TOLERANCE_RST;
    ph_kp[1] = 16'hffff;    ph_kd[1] = 16'hffff;   ph_tol[1] = 16'hffff;
    ph_kp[2] = 16'h0;       ph_kd[2] = 16'h0;      ph_tol[2] = 16'h0;
    ph_kp[3] = 16'd384;     ph_kd[3] = 16'd128;    ph_tol[3] = 16'd5;
    ph_kp[4] = 16'd1;       ph_kd[4] = 16'hffff;   ph_tol[4] = 16'd1;
    ph_kp[5] = 16'hffff;    ph_kd[5] = 16'h0;      ph_tol[5] = 16'd1;
    ph_kp[6] = 16'($urandom); ph_kd[6] = 16'($urandom);
    ph_tol[6] = 16'($urandom_range(1, 300));
    ph_kp[7] = 16'($urandom_range(32, 600)); ph_kd[7] = 16'($urandom_range(0, 255));
    ph_tol[7] = 16'($urandom_range(1, 60));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      program_gains(ph_kp[ph], ph_kd[ph], ph_tol[ph]);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        roll = $urandom_range(0, 99);
        if (roll < 72) begin
          // well-formed move: command, then samples creeping to the goal
          tl = pick_target();
          tr = pick_target();
          send_cmd(tl, tr);
          gl = plant_left + {{8{tl[23]}}, tl};
          gr = plant_right + {{8{tr[23]}}, tr};
          steps = $urandom_range(2, 40);
          repeat (steps) send_sample(approach(plant_left, gl), approach(plant_right, gr));
        end else if (roll < 90) begin
          // stray sample: full-range jump or small jitter
          if ($urandom_range(0, 1) == 0)
            send_sample($urandom, $urandom);
          else
            send_sample(plant_left + 32'($urandom_range(0, 20)) - 32'd10,
                        plant_right + 32'($urandom_range(0, 20)) - 32'd10);
        end else begin
          send_cmd(24'($urandom), 24'($urandom));
        end
      end
      drain();
    end

    $display("%0d items accepted over %0d gain settings, %0d results checked",
             items_accepted, NUM_PHASES, results_checked);
    $display("%0d commands finished, %0d left speeds at the clamp limit",
             done_seen, clamp_seen);
    if (error_count == 0) begin
      $display("dual_wheel_pd_position_drive_tb: clean");
    end else begin
      $display("dual_wheel_pd_position_drive_tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/dwpd_pkg.sv
hw/rtl/dwpd_front.sv
hw/rtl/dwpd_queue.sv
hw/rtl/dwpd_back.sv
hw/rtl/dual_wheel_pd_position_drive.sv
tb/dual_wheel_pd_position_drive_tb.sv
